// ===== rtl/twm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twm_pkg
// Shared constants, types and helpers of the thrust table and wrench mixer.
// ----------------------------------------------------------------------------
package twm_pkg;

	localparam int TABLE_POINTS = 81;
	localparam int MOTOR_COUNT  = 8;
	localparam int TAB_AW       = $clog2(TABLE_POINTS);
	localparam int MOT_AW       = $clog2(MOTOR_COUNT);
	localparam int ENTRY_W      = 32;   // {thrust, pwm}
	localparam int ACC_W        = 38;
	localparam int OUT_W        = 18;

	localparam logic [TAB_AW-1:0] LAST_IDX = TAB_AW'(TABLE_POINTS - 1);

	localparam logic signed [OUT_W-1:0] TORQUE_MAX = 18'sd131071;
	localparam logic signed [OUT_W-1:0] TORQUE_MIN = -18'sd131072;

	// register indexes of the configuration port
	localparam logic [2:0] REG_QUAD_PITCH  = 3'd0;
	localparam logic [2:0] REG_DRIVE_YAW   = 3'd1;
	localparam logic [2:0] REG_DRIVE_PITCH = 3'd2;
	localparam logic [2:0] REG_QUAD_ROLL   = 3'd3;
	localparam logic [2:0] REG_YAW_MOTOR   = 3'd4;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_MUL1,
		ST_MUL2,
		ST_DIVGO,
		ST_DIV,
		ST_STORE,
		ST_MIX,
		ST_DONE
	} state_t;

	// Q14.24 -> Q10.8, round half up, saturate
	function automatic logic signed [OUT_W-1:0] torque_round(
		input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0]    v;
		logic signed [ACC_W-16:0] r;
		begin
			v = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
			r = v[ACC_W:16];
			if (r > (ACC_W-15)'(TORQUE_MAX))
				torque_round = TORQUE_MAX;
			else if (r < (ACC_W-15)'(TORQUE_MIN))
				torque_round = TORQUE_MIN;
			else
				torque_round = r[OUT_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/twm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module twm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 81
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/twm_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twm_divider
// Restoring unsigned divider, 32 / 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twm_divider
	import twm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] r2;
	logic [17:0] diff;

	assign r2       = {rem_q, quo_q[31]};
	assign diff     = {1'b0, r2} - {2'b00, den_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= r2[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/thruster_wrench_mixer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thruster_wrench_mixer_top
// Breakpoint thrust table, per-motor interpolation and wrench mixing.
// ----------------------------------------------------------------------------
// Load request: written straight into the table RAM; an index past the
// end of the table is ignored. Convert request: per motor, a scan of the
// 81-entry table over one RAM read port, then the multiplier and divider
// when interpolating. One request at a time; s_tready is high only in idle.
// Reset (arst_n low) clears control and the arm registers to their defaults;
// the table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module thruster_wrench_mixer_top
	import twm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// entry_index[6:0], entry_pwm[22:7], entry_thrust[38:23],
	// pwm_0[54:39] .. pwm_7[166:151], zero pad [167]
	input  wire logic [167:0] s_tdata,
	input  wire logic         s_tuser,     // mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// force_drive[17:0], force_side[35:18], force_vertical[53:36],
	// torque_roll[71:54], torque_pitch[89:72], torque_yaw[107:90], pad
	output logic      [111:0] m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	// arm registers
	logic [15:0] qp_arm_q, dy_arm_q, dp_arm_q, qr_arm_q, ym_arm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_arm_q <= 16'd24770;
			dy_arm_q <= 16'd18810;
			dp_arm_q <= 16'd2314;
			qr_arm_q <= 16'd10620;
			ym_arm_q <= 16'd29797;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAD_PITCH:  qp_arm_q <= cfg_data;
				REG_DRIVE_YAW:   dy_arm_q <= cfg_data;
				REG_DRIVE_PITCH: dp_arm_q <= cfg_data;
				REG_QUAD_ROLL:   qr_arm_q <= cfg_data;
				REG_YAW_MOTOR:   ym_arm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic   s_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// table RAM: {thrust, pwm}
	logic [TAB_AW-1:0]  ld_idx;
	logic               ram_we;
	logic [TAB_AW-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [TAB_AW-1:0]  addr_q;
	logic               issue_done_q;

	assign ld_idx   = s_tdata[TAB_AW-1:0];
	assign ram_we   = s_acc && (s_tuser == MODE_LOAD) && (s_tdata[6:0] < 7'(TABLE_POINTS));
	assign ram_addr = (state_q == ST_IDLE) ? ld_idx : addr_q;

	twm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({s_tdata[38:23], s_tdata[22:7]}),
		.rdata (ram_rdata)
	);

	// motor commands of the request
	logic [15:0]       cmd_q [MOTOR_COUNT];
	logic [MOT_AW-1:0] mot_q;
	logic [15:0]       cmd;

	assign cmd = cmd_q[mot_q];

	// scan state
	logic              rd_vld_q;
	logic [TAB_AW-1:0] rd_idx_q;
	logic [15:0]       prev_x_q, x0_q, x1_q, x2_q;
	logic signed [15:0] prev_y_q, y0_q, yl_q, y1_q, y2_q;
	logic              found_q;
	logic [15:0]       cur_x;
	logic signed [15:0] cur_y;

	assign cur_x = ram_rdata[15:0];
	assign cur_y = ram_rdata[31:16];

	// shared multiply-accumulate
	logic signed [18:0]      mul_a;
	logic [16:0]             mul_b;
	logic signed [36:0]      prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = mul_a * $signed({1'b0, mul_b});

	// divider
	logic        div_start, div_done;
	logic [31:0] div_quo;
	logic [15:0] den;
	logic        neg;
	logic [31:0] mag;
	logic [31:0] dividend;

	assign den      = x2_q - x1_q;
	assign neg      = acc_q[ACC_W-1];
	assign mag      = neg ? 32'(-acc_q) : acc_q[31:0];
	assign dividend = mag + {17'd0, den[15:1]};
	assign div_start = (state_q == ST_DIVGO);

	twm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic signed [15:0] t_cur_q;
	logic signed [15:0] t_q [MOTOR_COUNT];
	logic [2:0]         mix_q;

	// mixing terms
	logic signed [18:0] s_roll, s_pitch, s_drive, s_yaw, s_dyaw, s_side, s_vert;
	assign s_roll  = -19'(t_q[4]) + 19'(t_q[5]) - 19'(t_q[6]) + 19'(t_q[7]);
	assign s_pitch = 19'(t_q[4]) + 19'(t_q[5]) - 19'(t_q[6]) - 19'(t_q[7]);
	assign s_vert  = 19'(t_q[4]) + 19'(t_q[5]) + 19'(t_q[6]) + 19'(t_q[7]);
	assign s_drive = 19'(t_q[2]) + 19'(t_q[3]);
	assign s_side  = 19'(t_q[0]) + 19'(t_q[1]);
	assign s_yaw   = 19'(t_q[0]) - 19'(t_q[1]);
	assign s_dyaw  = 19'(t_q[3]) - 19'(t_q[2]);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = 19'(y1_q);
				mul_b = 17'(x2_q) - 17'(cmd);
			end
			ST_MUL2: begin
				mul_a = 19'(y2_q);
				mul_b = 17'(cmd) - 17'(x1_q);
			end
			ST_MIX: begin
				unique case (mix_q)
					3'd0: begin mul_a = s_roll;  mul_b = 17'(qr_arm_q); end
					3'd1: begin mul_a = s_pitch; mul_b = 17'(qp_arm_q); end
					3'd2: begin mul_a = s_drive; mul_b = 17'(dp_arm_q); end
					3'd3: begin mul_a = s_yaw;   mul_b = 17'(ym_arm_q); end
					3'd4: begin mul_a = s_dyaw;  mul_b = 17'(dy_arm_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	logic scan_end;
	assign scan_end = rd_vld_q && (rd_idx_q == LAST_IDX);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_acc && s_tuser == MODE_CONVERT) state_d = ST_SCAN;
			ST_SCAN:  if (scan_end) state_d = ST_PICK;
			ST_PICK:  state_d = (found_q && x1_q != x2_q) ? ST_MUL1 : ST_STORE;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_DIVGO;
			ST_DIVGO: state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_STORE;
			ST_STORE: state_d = (mot_q == MOT_AW'(MOTOR_COUNT - 1)) ? ST_MIX : ST_SCAN;
			ST_MIX:   if (mix_q == 3'd5) state_d = ST_DONE;
			ST_DONE:  if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_q     <= 1'b0;
			mot_q        <= '0;
			mix_q        <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			// a new result replaces an accepted one in the same cycle
			if (state_q == ST_DONE && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			rd_vld_q <= (state_q == ST_SCAN) && !issue_done_q;
			unique case (state_q)
				ST_IDLE: begin
					addr_q       <= '0;
					issue_done_q <= 1'b0;
					mot_q        <= '0;
				end
				ST_SCAN: begin
					if (!issue_done_q) begin
						if (addr_q == LAST_IDX)
							issue_done_q <= 1'b1;
						else
							addr_q <= addr_q + 1'b1;
					end
				end
				ST_STORE: begin
					addr_q       <= '0;
					issue_done_q <= 1'b0;
					mix_q        <= '0;
					mot_q        <= mot_q + 1'b1;
				end
				ST_MIX: mix_q <= mix_q + 3'd1;
				default: ;
			endcase
		end
	end

	// datapath
	logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;

	always_ff @(posedge clk) begin
		rd_idx_q <= addr_q;
		if (s_acc) begin
			for (int k = 0; k < MOTOR_COUNT; k++)
				cmd_q[k] <= s_tdata[39 + 16*k +: 16];
		end
		unique case (state_q)
			ST_IDLE: found_q <= 1'b0;
			ST_SCAN: begin
				if (rd_vld_q) begin
					prev_x_q <= cur_x;
					prev_y_q <= cur_y;
					if (rd_idx_q == '0) begin
						x0_q <= cur_x;
						y0_q <= cur_y;
					end else if (prev_x_q <= cmd && cur_x >= cmd) begin
						found_q <= 1'b1;
						x1_q <= prev_x_q;
						y1_q <= prev_y_q;
						x2_q <= cur_x;
						y2_q <= cur_y;
					end
					if (rd_idx_q == LAST_IDX)
						yl_q <= cur_y;
				end
			end
			ST_PICK: begin
				if (!found_q)
					t_cur_q <= (cmd < x0_q) ? y0_q : yl_q;
				else
					t_cur_q <= y1_q;
			end
			ST_MUL1: acc_q <= ACC_W'(prod);
			ST_MUL2: acc_q <= acc_q + ACC_W'(prod);
			ST_DIV: begin
				if (div_done)
					t_cur_q <= neg ? -div_quo[15:0] : div_quo[15:0];
			end
			ST_STORE: begin
				t_q[mot_q] <= t_cur_q;
				found_q    <= 1'b0;
			end
			ST_MIX: begin
				unique case (mix_q)
					3'd0: acc_q <= ACC_W'(prod);
					3'd1: begin
						roll_q <= torque_round(acc_q);
						acc_q  <= ACC_W'(prod);
					end
					3'd2: acc_q <= acc_q + ACC_W'(prod);
					3'd3: begin
						pitch_q <= torque_round(acc_q);
						acc_q   <= ACC_W'(prod);
					end
					3'd4: acc_q <= acc_q + ACC_W'(prod);
					3'd5: yaw_q <= torque_round(acc_q);
					default: ;
				endcase
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready)
					m_tdata <= {4'd0, yaw_q, pitch_q, roll_q,
						s_vert[OUT_W-1:0], s_side[OUT_W-1:0], s_drive[OUT_W-1:0]};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== bench/thruster_wrench_mixer_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thruster_wrench_mixer_top_tb
// Loads breakpoint tables and streams convert requests with random stalls on
// both sides. A local model of the interpolation and wrench mixer predicts
// every result, and a monitor compares each field in arrival order.
// ----------------------------------------------------------------------------
module thruster_wrench_mixer_top_tb
	import twm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	// one expected wrench, fields in m_tdata order
	typedef struct packed {
		logic signed [17:0] tq_yaw;
		logic signed [17:0] tq_pitch;
		logic signed [17:0] tq_roll;
		logic signed [17:0] f_vert;
		logic signed [17:0] f_side;
		logic signed [17:0] f_drive;
	} wrench_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	// predictor state
	logic [15:0]        bp_cmd [TABLE_POINTS];
	logic signed [15:0] bp_thr [TABLE_POINTS];
	logic [15:0]        arm [5];
	wrench_t            wrench_q[$];
	int                 err_cnt = 0;
	int                 idle_cycles = 0;
	bit                 ready_idle_en = 1'b1;

	always #2 clk = ~clk;

	thruster_wrench_mixer_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// --- predictor -------------------------------------------------------
	function automatic longint rnd_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// last segment that holds the command wins; clamp outside the table
	function automatic longint cmd_to_thrust(logic [15:0] cmd);
		int seg;
		longint x1, x2, y1, y2;
		seg = -1;
		for (int i = 0; i + 1 < TABLE_POINTS; i++)
			if (bp_cmd[i] <= cmd && bp_cmd[i+1] >= cmd)
				seg = i;
		if (seg < 0)
			return (cmd < bp_cmd[0]) ? longint'(bp_thr[0]) : longint'(bp_thr[TABLE_POINTS-1]);
		x1 = bp_cmd[seg];
		x2 = bp_cmd[seg+1];
		y1 = bp_thr[seg];
		y2 = bp_thr[seg+1];
		if (x1 == x2)
			return y1;
		return rnd_div(y1 * (x2 - cmd) + y2 * (cmd - x1), x2 - x1);
	endfunction

	// Q14.24 to Q10.8, half up, saturated
	function automatic logic signed [17:0] torque_q88(longint acc);
		longint v, r;
		v = acc + 32768;
		r = (v >= 0) ? v / 65536 : -((-v + 65535) / 65536);
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return 18'(r);
	endfunction

	function automatic wrench_t mix_wrench(logic [167:0] d);
		longint t [8];
		wrench_t w;
		for (int m = 0; m < 8; m++)
			t[m] = cmd_to_thrust(d[39 + 16*m +: 16]);
		w.f_drive  = 18'(t[2] + t[3]);
		w.f_side   = 18'(t[0] + t[1]);
		w.f_vert   = 18'(t[4] + t[5] + t[6] + t[7]);
		w.tq_roll  = torque_q88(longint'(arm[REG_QUAD_ROLL]) * (-t[4] + t[5] - t[6] + t[7]));
		w.tq_pitch = torque_q88(longint'(arm[REG_QUAD_PITCH]) * (t[4] + t[5] - t[6] - t[7])
			+ longint'(arm[REG_DRIVE_PITCH]) * (t[2] + t[3]));
		w.tq_yaw   = torque_q88(longint'(arm[REG_YAW_MOTOR]) * (t[0] - t[1])
			+ longint'(arm[REG_DRIVE_YAW]) * (t[3] - t[2]));
		return w;
	endfunction

	// --- driver ----------------------------------------------------------
	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// send one request; random gap first, prediction updated on accept.
	// s_tvalid stays up after the accept: the next request or wait_idle
	// takes it down, so a zero gap keeps the stream continuous.
	task automatic send_request(logic mode, logic [167:0] d, bit gaps = 1'b1);
		int gap;
		gap = gaps ? int'($urandom_range(0, 5)) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			wait_cycles(gap);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_CONVERT) begin
			wrench_q.push_back(mix_wrench(d));
		end else if (d[6:0] < TABLE_POINTS) begin
			bp_cmd[d[6:0]] = d[22:7];
			bp_thr[d[6:0]] = d[38:23];
		end
	endtask

	task automatic load_entry(int idx, logic [15:0] cmd, logic [15:0] thr);
		logic [167:0] d;
		d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		d[6:0] = 7'(idx);
		d[22:7] = cmd;
		d[38:23] = thr;
		d[167] = 1'b0;
		send_request(MODE_LOAD, d);
	endtask

	task automatic convert(logic [15:0] c [8]);
		logic [167:0] d;
		d = '0;
		d[6:0] = 7'($urandom);
		d[38:7] = $urandom;
		for (int m = 0; m < 8; m++)
			d[39 + 16*m +: 16] = c[m];
		send_request(MODE_CONVERT, d);
	endtask

	// command near a breakpoint, on it, at 16'hFFFF, or anywhere
	function automatic logic [15:0] pick_cmd();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			return bp_cmd[$urandom_range(0, TABLE_POINTS-1)];
		if (k < 5)
			return 16'(bp_cmd[$urandom_range(0, TABLE_POINTS-1)] + $urandom_range(0, 6) - 3);
		if (k == 5)
			return (k & 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	task automatic random_converts(int n);
		logic [15:0] c [8];
		for (int i = 0; i < n; i++) begin
			for (int m = 0; m < 8; m++)
				c[m] = pick_cmd();
			convert(c);
		end
	endtask

	// drain results, then let the block settle before touching config
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (wrench_q.size() != 0)
			@(posedge clk);
		wait_cycles(20);
	endtask

	task automatic write_arm(logic [2:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_YAW_MOTOR)
			arm[idx] = val;
		@(posedge clk);
	endtask

	// full table: ascending, or flat/duplicated/descending regions by style
	task automatic load_table(int style);
		int cmd;
		cmd = (style == 0) ? 1000 : $urandom_range(0, 400);
		for (int i = 0; i < TABLE_POINTS; i++) begin
			case (style)
				0: begin
					load_entry(i, 16'(cmd), 16'(i * 400 - 16000));
					cmd += 800;
				end
				1: begin
					load_entry(i, 16'(cmd), 16'($urandom));
					if ($urandom_range(0, 3) != 0)
						cmd += $urandom_range(1, 1600);
				end
				default: begin
					// includes extreme thrusts and a possible wrap
					load_entry(i, 16'(cmd), (i % 2) ? 16'h7FFF : 16'h8000);
					cmd += $urandom_range(0, 1700);
				end
			endcase
		end
	endtask

	// --- tests -----------------------------------------------------------
	task automatic test_directed();
		logic [15:0] c [8];
		load_table(0);
		// below table, above table, exact ends, midpoints
		c = '{16'h0000, 16'hFFFF, 16'd1000, 16'd65000, 16'd1400, 16'd1401, 16'd33000, 16'd999};
		convert(c);
		c = '{16'hFFFF, 16'h0000, 16'd0, 16'hFFFF, 16'd65000, 16'd1000, 16'd1800, 16'd2600};
		convert(c);
		// ignored loads past the end of the table
		load_entry(81, 16'd5, 16'h1234);
		load_entry(127, 16'hFFFF, 16'h8000);
		// equal-ends segment and a broken (descending) spot
		load_entry(10, 16'd9000, 16'd777);
		load_entry(11, 16'd9000, 16'hF000);
		load_entry(20, 16'd100, 16'h7FFF);
		c = '{16'd9000, 16'd9000, 16'd100, 16'd16000, 16'd16200, 16'd500, 16'd9001, 16'd8999};
		convert(c);
		c = '{16'd17000, 16'd17400, 16'd16500, 16'd16600, 16'd100, 16'd99, 16'd17800, 16'd16999};
		convert(c);
	endtask

	task automatic test_arms();
		logic [15:0] c [8];
		logic [15:0] vals [3] = '{16'h0000, 16'hFFFF, 16'h8001};
		load_table(2);  // extreme thrusts drive torque saturation
		foreach (vals[v]) begin
			wait_idle();
			for (int r = 0; r <= REG_YAW_MOTOR; r++)
				write_arm(3'(r), vals[v]);
			write_arm(3'd5, 16'h1111);
			write_arm(3'd7, 16'h2222);
			for (int i = 0; i < 4; i++) begin
				for (int m = 0; m < 8; m++)
					c[m] = (m % 2 == i % 2) ? 16'h0000 : 16'hFFFF;
				convert(c);
			end
			random_converts(8);
		end
	endtask

	task automatic test_random();
		for (int p = 0; p < 3; p++) begin
			wait_idle();
			for (int r = 0; r <= REG_YAW_MOTOR; r++)
				write_arm(3'(r), 16'($urandom));
			load_table(p % 3);
			random_converts(40);
			// scattered rewrites and stray loads between conversions
			for (int i = 0; i < 20; i++) begin
				load_entry($urandom_range(0, 127), 16'($urandom), 16'($urandom));
				random_converts(1);
			end
		end
	endtask

	task automatic test_back_to_back();
		logic [167:0] d;
		ready_idle_en = 1'b0;
		for (int i = 0; i < 8; i++) begin
			d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			d[167] = 1'b0;
			send_request(MODE_CONVERT, d, 1'b0);
		end
		wait_idle();
		ready_idle_en = 1'b1;
	endtask

	// --- result monitor --------------------------------------------------
	always @(posedge clk) begin
		wrench_t got, exp_w;
		if (m_tvalid && m_tready) begin
			got = m_tdata[107:0];
			if (wrench_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				err_cnt++;
			end else begin
				exp_w = wrench_q.pop_front();
				if (got.f_drive !== exp_w.f_drive)
					$display("%0t: force_drive exp %0d got %0d", $time, exp_w.f_drive, got.f_drive);
				if (got.f_side !== exp_w.f_side)
					$display("%0t: force_side exp %0d got %0d", $time, exp_w.f_side, got.f_side);
				if (got.f_vert !== exp_w.f_vert)
					$display("%0t: force_vertical exp %0d got %0d", $time, exp_w.f_vert, got.f_vert);
				if (got.tq_roll !== exp_w.tq_roll)
					$display("%0t: torque_roll exp %0d got %0d", $time, exp_w.tq_roll, got.tq_roll);
				if (got.tq_pitch !== exp_w.tq_pitch)
					$display("%0t: torque_pitch exp %0d got %0d", $time, exp_w.tq_pitch, got.tq_pitch);
				if (got.tq_yaw !== exp_w.tq_yaw)
					$display("%0t: torque_yaw exp %0d got %0d", $time, exp_w.tq_yaw, got.tq_yaw);
				if (got !== exp_w)
					err_cnt++;
			end
		end
	end

	// receiver stalls: a fresh random hold-off after some results, none while ready_idle_en is clear
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!ready_idle_en || $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				stall = $urandom_range(0, 5);
				if (stall != 0) begin
					m_tready <= 1'b0;
					wait_cycles(stall);
				end
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("thruster_wrench_mixer_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_POINTS; i++) begin
			bp_cmd[i] = '0;
			bp_thr[i] = '0;
		end
		arm = '{16'd24770, 16'd18810, 16'd2314, 16'd10620, 16'd29797};
		wait_cycles(3);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_arms();
		test_random();
		test_back_to_back();
		wait_idle();
		if (err_cnt == 0)
			$display("thruster_wrench_mixer_top_tb: done, clean");
		else
			$display("thruster_wrench_mixer_top_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
